[rtl/taog_pkg.sv]
// Shared types and codes for the tiled array offset generator.
package taog_pkg;

  localparam logic [1:0] REQ_LOAD_BOTTOM = 2'd0;
  localparam logic [1:0] REQ_LOAD_TILE   = 2'd1;
  localparam logic [1:0] REQ_QUERY       = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_DIM   = 2'd1;
  localparam logic [1:0] ST_BAD_INDEX = 2'd2;
  localparam logic [1:0] ST_OVERFLOW  = 2'd3;

  localparam int CMD_DIM_W = 5;
  localparam int CMD_LVL_W = 4;

  localparam logic [4:0] OP_NONE        = 5'd0;
  localparam logic [4:0] OP_CAPTURE     = 5'd1;
  localparam logic [4:0] OP_WR_BL       = 5'd2;
  localparam logic [4:0] OP_WR_TC       = 5'd3;
  localparam logic [4:0] OP_RD_BL       = 5'd4;
  localparam logic [4:0] OP_RD_TC       = 5'd5;
  localparam logic [4:0] OP_DIV_INIT    = 5'd6;
  localparam logic [4:0] OP_DIV_STEP    = 5'd7;
  localparam logic [4:0] OP_FIN_POS     = 5'd8;
  localparam logic [4:0] OP_FIN_COORD   = 5'd9;
  localparam logic [4:0] OP_ACC_ES      = 5'd10;
  localparam logic [4:0] OP_ACC_TSIZE   = 5'd11;
  localparam logic [4:0] OP_TSIZE_ACC   = 5'd12;
  localparam logic [4:0] OP_MUL_RD      = 5'd13;
  localparam logic [4:0] OP_MUL_POS_OFF = 5'd14;
  localparam logic [4:0] OP_MUL_COORD   = 5'd15;
  localparam logic [4:0] OP_ADD_ACC     = 5'd16;

  typedef struct packed {
    logic [4:0]           op;
    logic [CMD_DIM_W-1:0] dim;
    logic [CMD_LVL_W-1:0] lvl;
    logic                 emit;
    logic                 final_q;
    logic [1:0]           code;
  } cmd_t;

  typedef struct packed {
    logic rd_zero;
    logic t_zero;
    logic div_last;
  } sts_t;

endpackage

[rtl/taog_datapath.sv]
// Datapath: length stores, shared divider, shared multiplier and result register.
module taog_datapath #(
  parameter int MAX_DIMS    = 8,
  parameter int MAX_LEVELS  = 4,
  parameter int OFFSET_BITS = 48
) (
  input  logic                   clk,
  input  logic                   rst,
  input  taog_pkg::cmd_t         cmd,
  output taog_pkg::sts_t         sts,
  input  logic [15:0]            element_size,
  input  logic [15:0]            length_value,
  input  logic [31:0]            coord_index,
  output logic                   done,
  output logic [OFFSET_BITS-1:0] offset,
  output logic [1:0]             status
);

  localparam int DIM_W    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int TC_DEPTH = MAX_DIMS * MAX_LEVELS;
  localparam int TC_AW    = (TC_DEPTH > 1) ? $clog2(TC_DEPTH) : 1;
  localparam int LVL_W    = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int PW       = OFFSET_BITS + 16;

  logic [15:0] bl_mem [MAX_DIMS];
  logic [15:0] tc_mem [TC_DEPTH];
  logic [15:0] coords [MAX_LEVELS];

  logic [15:0] length_q;
  logic [15:0] rd;
  logic [31:0] t;
  logic [15:0] pos;
  logic [31:0] dq;
  logic [15:0] drem;
  logic [15:0] dden;
  logic [4:0]  dcnt;

  logic                   acc_o, off_o, tsize_o;
  logic [OFFSET_BITS-1:0] acc_v, off_v, tsize_v;

  logic [DIM_W-1:0] bl_addr;
  logic [7:0]       tc_lin;
  logic [TC_AW-1:0] tc_addr;
  logic [LVL_W-1:0] lvl_idx;

  logic [15:0]            mul_b;
  logic [PW-1:0]          prod;
  logic                   mul_zero, mul_o;
  logic [OFFSET_BITS-1:0] mul_v;
  logic [OFFSET_BITS:0]   sum;
  logic                   add_o;
  logic [OFFSET_BITS-1:0] add_v;
  logic [16:0]            rshift;
  logic                   ge;

  assign bl_addr = cmd.dim[DIM_W-1:0];
  assign tc_lin  = 8'(cmd.dim) * 8'(MAX_LEVELS) + 8'(cmd.lvl);
  assign tc_addr = tc_lin[TC_AW-1:0];
  assign lvl_idx = cmd.lvl[LVL_W-1:0];

  // One multiplier for every product; a zero operand wins over an overflowed one.
  always_comb begin
    case (cmd.op)
      taog_pkg::OP_MUL_COORD:   mul_b = coords[lvl_idx];
      taog_pkg::OP_MUL_POS_OFF: mul_b = pos;
      default:                  mul_b = rd;
    endcase
  end

  assign prod     = PW'(acc_v) * PW'(mul_b);
  assign mul_zero = (!acc_o && (acc_v == '0)) || (mul_b == 16'd0);
  assign mul_o    = !mul_zero && (acc_o || (|prod[PW-1:OFFSET_BITS]));
  assign mul_v    = (mul_zero || mul_o) ? '0 : prod[OFFSET_BITS-1:0];

  assign sum   = {1'b0, off_v} + {1'b0, acc_v};
  assign add_o = off_o || acc_o || sum[OFFSET_BITS];
  assign add_v = add_o ? '0 : sum[OFFSET_BITS-1:0];

  // Restoring divider, one quotient bit per step.
  assign rshift = {drem, dq[31]};
  assign ge     = (rshift >= {1'b0, dden});

  assign sts.rd_zero  = (rd == 16'd0);
  assign sts.t_zero   = (t == 32'd0);
  assign sts.div_last = (dcnt == 5'd31);

  always_ff @(posedge clk) begin
    case (cmd.op)
      taog_pkg::OP_CAPTURE: begin
        length_q <= length_value;
        t        <= coord_index;
      end
      taog_pkg::OP_WR_BL:  bl_mem[bl_addr] <= length_q;
      taog_pkg::OP_WR_TC:  tc_mem[tc_addr] <= length_q;
      taog_pkg::OP_RD_BL:  rd <= bl_mem[bl_addr];
      taog_pkg::OP_RD_TC:  rd <= tc_mem[tc_addr];
      taog_pkg::OP_DIV_INIT: begin
        dq   <= t;
        drem <= 16'd0;
        dden <= rd;
        dcnt <= 5'd0;
      end
      taog_pkg::OP_DIV_STEP: begin
        dq   <= {dq[30:0], ge};
        drem <= ge ? 16'(rshift - {1'b0, dden}) : rshift[15:0];
        dcnt <= dcnt + 5'd1;
      end
      taog_pkg::OP_FIN_POS: begin
        pos <= drem;
        t   <= dq;
      end
      taog_pkg::OP_FIN_COORD: begin
        coords[lvl_idx] <= drem;
        t               <= dq;
      end
      taog_pkg::OP_ACC_ES: begin
        acc_v <= OFFSET_BITS'(element_size);
        acc_o <= 1'b0;
      end
      taog_pkg::OP_ACC_TSIZE: begin
        acc_v <= tsize_v;
        acc_o <= tsize_o;
      end
      taog_pkg::OP_TSIZE_ACC: begin
        tsize_v <= acc_v;
        tsize_o <= acc_o;
      end
      taog_pkg::OP_MUL_RD, taog_pkg::OP_MUL_COORD: begin
        acc_v <= mul_v;
        acc_o <= mul_o;
      end
      taog_pkg::OP_MUL_POS_OFF: begin
        off_v <= mul_v;
        off_o <= mul_o;
      end
      taog_pkg::OP_ADD_ACC: begin
        off_v <= add_v;
        off_o <= add_o;
      end
      default: ;
    endcase
    if (cmd.emit) begin
      if (cmd.final_q) begin
        status <= off_o ? taog_pkg::ST_OVERFLOW : taog_pkg::ST_OK;
        offset <= off_o ? '0 : off_v;
      end else begin
        status <= cmd.code;
        offset <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

endmodule

[rtl/taog_ctrl.sv]
// Controller: sequences loads and the query's divisions and products.
module taog_ctrl #(
  parameter int MAX_DIMS   = 8,
  parameter int MAX_LEVELS = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [1:0]     req_type,
  input  logic [2:0]     dim_index,
  input  logic [1:0]     level_index,
  input  logic [3:0]     num_dims,
  input  logic [2:0]     tile_levels,
  input  taog_pkg::sts_t sts,
  output taog_pkg::cmd_t cmd,
  output logic           busy
);

  localparam int KW = $clog2(MAX_DIMS + 1);
  localparam int LW = $clog2(MAX_LEVELS + 1);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_DISP  = 5'd1;
  localparam logic [4:0] S_BLCHK = 5'd2;
  localparam logic [4:0] S_DIV0  = 5'd3;
  localparam logic [4:0] S_POSF  = 5'd4;
  localparam logic [4:0] S_LVL   = 5'd5;
  localparam logic [4:0] S_LCHK  = 5'd6;
  localparam logic [4:0] S_DIVL  = 5'd7;
  localparam logic [4:0] S_LFIN  = 5'd8;
  localparam logic [4:0] S_TCHK  = 5'd9;
  localparam logic [4:0] S_STR   = 5'd10;
  localparam logic [4:0] S_STRM  = 5'd11;
  localparam logic [4:0] S_TS0   = 5'd12;
  localparam logic [4:0] S_TSI   = 5'd13;
  localparam logic [4:0] S_TSIM  = 5'd14;
  localparam logic [4:0] S_LV2   = 5'd15;
  localparam logic [4:0] S_BLK   = 5'd16;
  localparam logic [4:0] S_BLKM  = 5'd17;
  localparam logic [4:0] S_ADD   = 5'd18;
  localparam logic [4:0] S_TSL0  = 5'd19;
  localparam logic [4:0] S_TSL   = 5'd20;
  localparam logic [4:0] S_TSLM  = 5'd21;
  localparam logic [4:0] S_EMIT  = 5'd22;

  logic [4:0]    state, state_next;
  logic [KW-1:0] k, k_next;
  logic [LW-1:0] l, l_next;
  logic [1:0]    req_q;
  logic [2:0]    dim_q;
  logic [1:0]    lvl_q;

  logic [4:0]    nd_w;
  logic [KW-1:0] nd;
  logic [3:0]    nl_w;
  logic [LW-1:0] nl;
  logic          dim_in_use, dim_in_store, lvl_in_store;

  assign nd_w = (5'(num_dims) > 5'(MAX_DIMS)) ? 5'(MAX_DIMS) : 5'(num_dims);
  assign nd   = nd_w[KW-1:0];
  assign nl_w = (4'(tile_levels) > 4'(MAX_LEVELS)) ? 4'(MAX_LEVELS) : 4'(tile_levels);
  assign nl   = nl_w[LW-1:0];

  assign dim_in_use   = 5'(dim_q) < nd_w;
  assign dim_in_store = 5'(dim_q) < 5'(MAX_DIMS);
  assign lvl_in_store = 4'(lvl_q) < 4'(MAX_LEVELS);

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    k_next     = k;
    l_next     = l;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.op     = taog_pkg::OP_CAPTURE;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        cmd.dim = taog_pkg::CMD_DIM_W'(dim_q);
        cmd.lvl = taog_pkg::CMD_LVL_W'(lvl_q);
        case (req_q)
          taog_pkg::REQ_LOAD_BOTTOM: begin
            if (dim_in_store) cmd.op = taog_pkg::OP_WR_BL;
            cmd.emit   = 1'b1;
            state_next = S_IDLE;
          end
          taog_pkg::REQ_LOAD_TILE: begin
            if (dim_in_store && lvl_in_store) cmd.op = taog_pkg::OP_WR_TC;
            cmd.emit   = 1'b1;
            state_next = S_IDLE;
          end
          taog_pkg::REQ_QUERY: begin
            if (!dim_in_use) begin
              cmd.emit   = 1'b1;
              cmd.code   = taog_pkg::ST_BAD_DIM;
              state_next = S_IDLE;
            end else begin
              cmd.op     = taog_pkg::OP_RD_BL;
              state_next = S_BLCHK;
            end
          end
          default: begin
            cmd.emit   = 1'b1;
            state_next = S_IDLE;
          end
        endcase
      end
      S_BLCHK: begin
        if (sts.rd_zero) begin
          cmd.emit   = 1'b1;
          cmd.code   = taog_pkg::ST_BAD_INDEX;
          state_next = S_IDLE;
        end else begin
          cmd.op     = taog_pkg::OP_DIV_INIT;
          state_next = S_DIV0;
        end
      end
      S_DIV0: begin
        cmd.op = taog_pkg::OP_DIV_STEP;
        if (sts.div_last) state_next = S_POSF;
      end
      S_POSF: begin
        cmd.op     = taog_pkg::OP_FIN_POS;
        l_next     = nl;
        state_next = S_LVL;
      end
      // Tile coordinates come out deepest level first.
      S_LVL: begin
        if (l == '0) begin
          state_next = S_TCHK;
        end else begin
          cmd.op     = taog_pkg::OP_RD_TC;
          cmd.dim    = taog_pkg::CMD_DIM_W'(dim_q);
          cmd.lvl    = taog_pkg::CMD_LVL_W'(l - LW'(1));
          l_next     = l - LW'(1);
          state_next = S_LCHK;
        end
      end
      S_LCHK: begin
        if (sts.rd_zero) begin
          cmd.emit   = 1'b1;
          cmd.code   = taog_pkg::ST_BAD_INDEX;
          state_next = S_IDLE;
        end else begin
          cmd.op     = taog_pkg::OP_DIV_INIT;
          state_next = S_DIVL;
        end
      end
      S_DIVL: begin
        cmd.op = taog_pkg::OP_DIV_STEP;
        if (sts.div_last) state_next = S_LFIN;
      end
      S_LFIN: begin
        cmd.op     = taog_pkg::OP_FIN_COORD;
        cmd.lvl    = taog_pkg::CMD_LVL_W'(l);
        state_next = S_LVL;
      end
      S_TCHK: begin
        if (!sts.t_zero) begin
          cmd.emit   = 1'b1;
          cmd.code   = taog_pkg::ST_BAD_INDEX;
          state_next = S_IDLE;
        end else begin
          cmd.op     = taog_pkg::OP_ACC_ES;
          k_next     = KW'(dim_q) + KW'(1);
          state_next = S_STR;
        end
      end
      S_STR: begin
        if (k >= nd) begin
          cmd.op     = taog_pkg::OP_MUL_POS_OFF;
          state_next = (nl == '0) ? S_EMIT : S_TS0;
        end else begin
          cmd.op     = taog_pkg::OP_RD_BL;
          cmd.dim    = taog_pkg::CMD_DIM_W'(k);
          state_next = S_STRM;
        end
      end
      S_STRM: begin
        cmd.op     = taog_pkg::OP_MUL_RD;
        k_next     = k + KW'(1);
        state_next = S_STR;
      end
      S_TS0: begin
        cmd.op     = taog_pkg::OP_ACC_ES;
        k_next     = '0;
        state_next = S_TSI;
      end
      S_TSI: begin
        if (k >= nd) begin
          cmd.op     = taog_pkg::OP_TSIZE_ACC;
          l_next     = nl;
          state_next = S_LV2;
        end else begin
          cmd.op     = taog_pkg::OP_RD_BL;
          cmd.dim    = taog_pkg::CMD_DIM_W'(k);
          state_next = S_TSIM;
        end
      end
      S_TSIM: begin
        cmd.op     = taog_pkg::OP_MUL_RD;
        k_next     = k + KW'(1);
        state_next = S_TSI;
      end
      S_LV2: begin
        if (l == '0) begin
          state_next = S_EMIT;
        end else begin
          cmd.op     = taog_pkg::OP_ACC_TSIZE;
          l_next     = l - LW'(1);
          k_next     = KW'(dim_q) + KW'(1);
          state_next = S_BLK;
        end
      end
      S_BLK: begin
        cmd.lvl = taog_pkg::CMD_LVL_W'(l);
        if (k >= nd) begin
          cmd.op     = taog_pkg::OP_MUL_COORD;
          state_next = S_ADD;
        end else begin
          cmd.op     = taog_pkg::OP_RD_TC;
          cmd.dim    = taog_pkg::CMD_DIM_W'(k);
          state_next = S_BLKM;
        end
      end
      S_BLKM: begin
        cmd.op     = taog_pkg::OP_MUL_RD;
        k_next     = k + KW'(1);
        state_next = S_BLK;
      end
      S_ADD: begin
        cmd.op     = taog_pkg::OP_ADD_ACC;
        k_next     = '0;
        state_next = S_TSL0;
      end
      S_TSL0: begin
        cmd.op     = taog_pkg::OP_ACC_TSIZE;
        state_next = S_TSL;
      end
      S_TSL: begin
        if (k >= nd) begin
          cmd.op     = taog_pkg::OP_TSIZE_ACC;
          state_next = S_LV2;
        end else begin
          cmd.op     = taog_pkg::OP_RD_TC;
          cmd.dim    = taog_pkg::CMD_DIM_W'(k);
          cmd.lvl    = taog_pkg::CMD_LVL_W'(l);
          state_next = S_TSLM;
        end
      end
      S_TSLM: begin
        cmd.op     = taog_pkg::OP_MUL_RD;
        k_next     = k + KW'(1);
        state_next = S_TSL;
      end
      S_EMIT: begin
        cmd.emit    = 1'b1;
        cmd.final_q = 1'b1;
        state_next  = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      k     <= '0;
      l     <= '0;
    end else begin
      state <= state_next;
      k     <= k_next;
      l     <= l_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      req_q <= req_type;
      dim_q <= dim_index;
      lvl_q <= level_index;
    end
  end

endmodule

[rtl/tiled_array_offset_generator.sv]
// Top level of the tiled array offset generator: register port, controller, datapath.
//
// Items enter on start while busy is low: a load of a bottom length, a load of
// a tile count, or an offset query along one dimension. Every accepted item
// gives exactly one result beat: done is high for one cycle with offset and
// status; the receiver cannot stall, so it must take the beat in that cycle.
// Loads pass through the idle capture and the dispatch state before done, as does
// a query on a dimension not in use. A query divides the index by the bottom length
// on a shared restoring divider, then by one tile count per level, then forms
// strides and block sizes on one shared multiplier, with a memory read before each
// product by a stored length. One item is in flight at a time; busy drops as done
// rises. Registers element_size, num_dims and the tiling level count sit on the
// APB-style port at byte addresses 0, 4 and 8; the user must write them only
// while busy is low, and the block itself does not enforce this. Reset restores
// element_size 1, num_dims 1, no tiling levels and clears the controller; the
// length stores hold nothing valid until loaded.
module tiled_array_offset_generator #(
  parameter int MAX_DIMS    = 8,
  parameter int MAX_LEVELS  = 4,
  parameter int OFFSET_BITS = 48
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             req_type,
  input  logic [2:0]             dim_index,
  input  logic [1:0]             level_index,
  input  logic [15:0]            length_value,
  input  logic [31:0]            coord_index,
  output logic                   done,
  output logic [OFFSET_BITS-1:0] offset,
  output logic [1:0]             status,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [3:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam logic [1:0] REG_ELEMENT_SIZE = 2'd0;
  localparam logic [1:0] REG_NUM_DIMS     = 2'd1;
  localparam logic [1:0] REG_TILE_LEVELS  = 2'd2;

  logic [15:0] element_size;
  logic [3:0]  num_dims;
  logic [2:0]  tile_levels;
  logic        cfg_wr;

  taog_pkg::cmd_t cmd;
  taog_pkg::sts_t sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      element_size <= 16'd1;
      num_dims     <= 4'd1;
      tile_levels  <= 3'd0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_ELEMENT_SIZE: element_size <= pwdata[15:0];
        REG_NUM_DIMS:     num_dims     <= pwdata[3:0];
        REG_TILE_LEVELS:  tile_levels  <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ELEMENT_SIZE: prdata = 32'(element_size);
      REG_NUM_DIMS:     prdata = 32'(num_dims);
      REG_TILE_LEVELS:  prdata = 32'(tile_levels);
      default:          prdata = 32'd0;
    endcase
  end

  taog_ctrl #(
    .MAX_DIMS   (MAX_DIMS),
    .MAX_LEVELS (MAX_LEVELS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .req_type    (req_type),
    .dim_index   (dim_index),
    .level_index (level_index),
    .num_dims    (num_dims),
    .tile_levels (tile_levels),
    .sts         (sts),
    .cmd         (cmd),
    .busy        (busy)
  );

  taog_datapath #(
    .MAX_DIMS    (MAX_DIMS),
    .MAX_LEVELS  (MAX_LEVELS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .element_size (element_size),
    .length_value (length_value),
    .coord_index  (coord_index),
    .done         (done),
    .offset       (offset),
    .status       (status)
  );

  // A result beat only follows a cycle of work on an item.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result beat without an item in flight");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted item dropped");

  a_error_zero_offset: assert property (@(posedge clk) disable iff (rst)
    (done && status != taog_pkg::ST_OK) |-> (offset == '0))
    else $error("nonzero offset on an error beat");

endmodule

[tb/sv/taog_tb_pkg.sv]
// Register addresses and sizes shared by the offset generator testbench files.
package taog_tb_pkg;

  localparam logic [3:0] ADDR_ELEMENT_SIZE = 4'd0;
  localparam logic [3:0] ADDR_NUM_DIMS     = 4'd4;
  localparam logic [3:0] ADDR_NUM_LEVELS   = 4'd8;

  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam int N_DIMS   = 8;
  localparam int N_LEVELS = 4;

endpackage

[tb/sv/taog_checker.sv]
// Checker for the offset generator: predicts each beat's offset and status and compares.
module taog_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  req_type,
  input  logic [2:0]  dim_index,
  input  logic [1:0]  level_index,
  input  logic [15:0] length_value,
  input  logic [31:0] coord_index,
  input  logic        done,
  input  logic [47:0] offset,
  input  logic [1:0]  status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output int          errors,
  output int          pending,
  output int          n_loads,
  output int          n_good,
  output int          n_bad_dim,
  output int          n_bad_index,
  output int          n_overflow
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] OFFSET_MAX = 64'h0000_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic        over;
    logic [63:0] v;
  } bounded_t;

  typedef struct packed {
    logic [47:0] offset;
    logic [1:0]  status;
  } answer_t;

  logic [15:0] bottom_len [taog_tb_pkg::N_DIMS];
  logic [15:0] tile_cnt [taog_tb_pkg::N_DIMS][taog_tb_pkg::N_LEVELS];
  logic [15:0] elem_size;
  logic [3:0]  dims_cfg;
  logic [2:0]  levels_cfg;
  answer_t     answers_due [$];

  function automatic bounded_t bounded(logic [63:0] x);
    bounded_t r;
    r.over = x > OFFSET_MAX;
    r.v = r.over ? 64'd0 : x;
    return r;
  endfunction

  // A known zero wins over an earlier overflow, as the products are exact.
  function automatic bounded_t bmul(bounded_t a, bounded_t b);
    bounded_t r;
    r = '0;
    if ((!a.over && a.v == 0) || (!b.over && b.v == 0)) return r;
    if (a.over || b.over || a.v > OFFSET_MAX / b.v) r.over = 1'b1;
    else r.v = a.v * b.v;
    return r;
  endfunction

  function automatic bounded_t badd(bounded_t a, bounded_t b);
    bounded_t r;
    r = '0;
    if (a.over || b.over || a.v > OFFSET_MAX - b.v) r.over = 1'b1;
    else r.v = a.v + b.v;
    return r;
  endfunction

  function automatic answer_t locate(logic [2:0] dim, logic [31:0] idx);
    answer_t     r;
    int          nd, nl;
    logic [63:0] blen, pos, t, c;
    logic [63:0] coord [taog_tb_pkg::N_LEVELS];
    bounded_t    stride, off, tsize, blk;
    r = '0;
    nd = (dims_cfg > taog_tb_pkg::N_DIMS) ? taog_tb_pkg::N_DIMS : dims_cfg;
    nl = (levels_cfg > taog_tb_pkg::N_LEVELS) ? taog_tb_pkg::N_LEVELS : levels_cfg;
    if (dim >= nd) begin
      r.status = taog_pkg::ST_BAD_DIM;
      return r;
    end
    blen = bottom_len[dim];
    if (blen == 0) begin
      r.status = taog_pkg::ST_BAD_INDEX;
      return r;
    end
    pos = idx % blen;
    t = idx / blen;
    for (int l = nl - 1; l >= 0; l--) begin
      c = tile_cnt[dim][l];
      if (c == 0) begin
        r.status = taog_pkg::ST_BAD_INDEX;
        return r;
      end
      coord[l] = t % c;
      t = t / c;
    end
    if (t != 0) begin
      r.status = taog_pkg::ST_BAD_INDEX;
      return r;
    end
    stride = bounded(elem_size);
    for (int k = dim + 1; k < nd; k++) stride = bmul(stride, bounded(bottom_len[k]));
    off = bmul(stride, bounded(pos));
    if (nl > 0) begin
      tsize = bounded(elem_size);
      for (int k = 0; k < nd; k++) tsize = bmul(tsize, bounded(bottom_len[k]));
      for (int l = nl - 1; l >= 0; l--) begin
        blk = tsize;
        for (int k = dim + 1; k < nd; k++) blk = bmul(blk, bounded(tile_cnt[k][l]));
        off = badd(off, bmul(blk, bounded(coord[l])));
        for (int k = 0; k < nd; k++) tsize = bmul(tsize, bounded(tile_cnt[k][l]));
      end
    end
    if (off.over) r.status = taog_pkg::ST_OVERFLOW;
    else r.offset = off.v[47:0];
    return r;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
  endtask

  initial begin
    errors = 0;
    pending = 0;
    n_loads = 0;
    n_good = 0;
    n_bad_dim = 0;
    n_bad_index = 0;
    n_overflow = 0;
  end

  always @(posedge clk) begin
    answer_t a;
    if (rst) begin
      elem_size = 16'd1;
      dims_cfg = 4'd1;
      levels_cfg = 3'd0;
      answers_due.delete();
      pending = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          taog_tb_pkg::ADDR_ELEMENT_SIZE: elem_size = pwdata[15:0];
          taog_tb_pkg::ADDR_NUM_DIMS:     dims_cfg = pwdata[3:0];
          taog_tb_pkg::ADDR_NUM_LEVELS:   levels_cfg = pwdata[2:0];
          default: ;
        endcase
      end
      if (done) begin
        if (answers_due.size() == 0) begin
          report("unexpected beat, offset", offset, 0);
        end else begin
          a = answers_due.pop_front();
          pending--;
          if (offset !== a.offset) report("offset", offset, a.offset);
          if (status !== a.status) report("status", status, a.status);
        end
      end
      if (start && !busy) begin
        a = '0;
        case (req_type)
          taog_pkg::REQ_LOAD_BOTTOM: begin
            bottom_len[dim_index] = length_value;
            n_loads++;
          end
          taog_pkg::REQ_LOAD_TILE: begin
            tile_cnt[dim_index][level_index] = length_value;
            n_loads++;
          end
          taog_pkg::REQ_QUERY: begin
            a = locate(dim_index, coord_index);
            case (a.status)
              taog_pkg::ST_OK:        n_good++;
              taog_pkg::ST_BAD_DIM:   n_bad_dim++;
              taog_pkg::ST_BAD_INDEX: n_bad_index++;
              default:                n_overflow++;
            endcase
          end
          default: ;
        endcase
        answers_due.push_back(a);
        pending++;
      end
    end
  end

endmodule

[tb/sv/testbench.sv]
// Top of the offset generator testbench: clock, reset, stimulus and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int N_PHASES = 12;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  req_type = '0;
  logic [2:0]  dim_index = '0;
  logic [1:0]  level_index = '0;
  logic [15:0] length_value = '0;
  logic [31:0] coord_index = '0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic        busy, done, pready;
  logic [47:0] offset;
  logic [1:0]  status;
  logic [31:0] prdata;
  int          errors, pending, n_loads, n_good, n_bad_dim, n_bad_index, n_overflow;
  int          cycles = 0;
  bit          gaps_on = 1'b1;

  // Shadow of the loaded lengths, used only to aim query indices near the valid range.
  logic [15:0] bl_shadow [taog_tb_pkg::N_DIMS];
  logic [15:0] tc_shadow [taog_tb_pkg::N_DIMS][taog_tb_pkg::N_LEVELS];
  int          dims_now = 1;
  int          levels_now = 0;

  tiled_array_offset_generator DUT (
    .clk, .rst, .start, .busy, .req_type, .dim_index, .level_index, .length_value,
    .coord_index, .done, .offset, .status, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready
  );

  taog_checker u_checker (
    .clk, .rst, .start, .busy, .req_type, .dim_index, .level_index, .length_value,
    .coord_index, .done, .offset, .status, .psel, .penable, .pwrite, .pready, .paddr,
    .pwdata, .errors, .pending, .n_loads, .n_good, .n_bad_dim, .n_bad_index, .n_overflow
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_beat(logic [1:0] rq, logic [2:0] d, logic [1:0] l,
                           logic [15:0] v, logic [31:0] idx);
    @(negedge clk);
    start <= 1'b1;
    req_type <= rq;
    dim_index <= d;
    level_index <= l;
    length_value <= v;
    coord_index <= idx;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (rq == taog_pkg::REQ_LOAD_BOTTOM) bl_shadow[d] = v;
    if (rq == taog_pkg::REQ_LOAD_TILE) tc_shadow[d][l] = v;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(0, 17)) @(negedge clk);
    end
  endtask

  task automatic drain;
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0 || busy) @(negedge clk);
  endtask

  task automatic reg_write(logic [3:0] addr, logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic configure(logic [15:0] es, logic [3:0] nd, logic [2:0] nl);
    drain();
    reg_write(taog_tb_pkg::ADDR_ELEMENT_SIZE, {$urandom} & 32'hFFFF_0000 | es);
    reg_write(taog_tb_pkg::ADDR_NUM_DIMS, {$urandom} & 32'hFFFF_FFF0 | nd);
    reg_write(taog_tb_pkg::ADDR_NUM_LEVELS, {$urandom} & 32'hFFFF_FFF8 | nl);
    dims_now = (nd > taog_tb_pkg::N_DIMS) ? taog_tb_pkg::N_DIMS : nd;
    levels_now = (nl > taog_tb_pkg::N_LEVELS) ? taog_tb_pkg::N_LEVELS : nl;
  endtask

  function automatic logic [15:0] pick_length(int mode);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return 16'd0;
    if (r < 6) return 16'hFFFF;
    case (mode)
      0: return 16'($urandom_range(1, 6));
      1: return 16'($urandom_range(1, 300));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_index(logic [2:0] d);
    logic [127:0] span;
    int           r;
    span = bl_shadow[d];
    for (int l = 0; l < levels_now; l++) span = span * tc_shadow[d][l];
    r = $urandom_range(0, 99);
    if (span == 0 || r < 15) return $urandom;
    if (span > 128'hFFFF_FFFF) return $urandom;
    if (r < 22) return 32'(span - 1);
    if (r < 26) return 32'(span);
    if (r < 30) return 32'd0;
    return 32'({$urandom} % span[31:0]);
  endfunction

  task automatic fill_store(int mode);
    for (int d = 0; d < taog_tb_pkg::N_DIMS; d++) begin
      send_beat(taog_pkg::REQ_LOAD_BOTTOM, 3'(d), 2'($urandom), pick_length(mode), $urandom);
      for (int l = 0; l < taog_tb_pkg::N_LEVELS; l++)
        send_beat(taog_pkg::REQ_LOAD_TILE, 3'(d), 2'(l), pick_length(mode), $urandom);
    end
  endtask

  initial begin
    int mode, r, nd_pick;
    logic [15:0] es_pick;
    logic [2:0]  d;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Every store entry is loaded before the first query can read it.
    fill_store(0);

    // Directed beats under the reset configuration, a wide one and two more settings.
    send_beat(taog_pkg::REQ_QUERY, 3'd0, 2'd0, 16'd0, 32'd0);
    send_beat(taog_pkg::REQ_QUERY, 3'd0, 2'd3, 16'hFFFF, 32'hFFFF_FFFF);
    send_beat(taog_pkg::REQ_QUERY, 3'd1, 2'd0, 16'd0, 32'd0);
    send_beat(taog_pkg::REQ_QUERY, 3'd7, 2'd0, 16'd0, 32'd1);
    send_beat(taog_tb_pkg::REQ_UNUSED, 3'd7, 2'd3, 16'hFFFF, 32'hFFFF_FFFF);
    send_beat(taog_pkg::REQ_LOAD_BOTTOM, 3'd0, 2'd0, 16'hFFFF, 32'd0);
    send_beat(taog_pkg::REQ_QUERY, 3'd0, 2'd0, 16'd0, 32'd65534);
    send_beat(taog_pkg::REQ_QUERY, 3'd0, 2'd0, 16'd0, 32'd65535);
    send_beat(taog_pkg::REQ_LOAD_BOTTOM, 3'd0, 2'd0, 16'd0, 32'd0);
    send_beat(taog_pkg::REQ_QUERY, 3'd0, 2'd0, 16'd0, 32'd0);
    configure(16'hFFFF, 4'd8, 3'd4);
    fill_store(2);
    send_beat(taog_pkg::REQ_QUERY, 3'd7, 2'd0, 16'd0, 32'd0);
    send_beat(taog_pkg::REQ_QUERY, 3'd0, 2'd0, 16'd0, 32'hFFFF_FFFF);
    send_beat(taog_pkg::REQ_QUERY, 3'd3, 2'd0, 16'd0, 32'h0001_0000);
    configure(16'd0, 4'd15, 3'd7);
    send_beat(taog_pkg::REQ_QUERY, 3'd7, 2'd0, 16'd0, 32'd5);
    configure(16'd1, 4'd0, 3'd0);
    send_beat(taog_pkg::REQ_QUERY, 3'd0, 2'd0, 16'd0, 32'd0);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      r = $urandom_range(0, 9);
      es_pick = (r < 2) ? 16'd1 : (r < 3) ? 16'hFFFF : (r < 4) ? 16'd0 : 16'($urandom);
      if (r >= 4 && r < 8) es_pick = 16'($urandom_range(1, 16));
      nd_pick = (ph % 4 == 0) ? 8 : (ph % 4 == 1) ? 1 : $urandom_range(0, 15);
      configure(es_pick, 4'(nd_pick), 3'(ph == 3 ? 7 : $urandom_range(0, 4)));
      mode = ph % 3;
      gaps_on = (ph < N_PHASES - 2);
      fill_store(mode);
      for (int i = 0; i < 56; i++) begin
        r = $urandom_range(0, 99);
        d = (dims_now > 0 && r % 7 != 0) ? 3'($urandom_range(0, dims_now - 1)) : 3'($urandom);
        if (r < 8)
          send_beat(taog_pkg::REQ_LOAD_BOTTOM, 3'($urandom), 2'($urandom),
                    pick_length(mode), $urandom);
        else if (r < 16)
          send_beat(taog_pkg::REQ_LOAD_TILE, 3'($urandom), 2'($urandom),
                    pick_length(mode), $urandom);
        else if (r < 20)
          send_beat(taog_tb_pkg::REQ_UNUSED, 3'($urandom), 2'($urandom), 16'($urandom),
                    $urandom);
        else
          send_beat(taog_pkg::REQ_QUERY, d, 2'($urandom), 16'($urandom), pick_index(d));
      end
    end

    drain();
    repeat (400) @(posedge clk);
    $display("covered %0d loads and %0d queries over %0d register settings",
             n_loads, n_good + n_bad_dim + n_bad_index + n_overflow, N_PHASES + 3);
    $display("query outcomes: %0d good, %0d bad dimension, %0d bad index, %0d overflow",
             n_good, n_bad_dim, n_bad_index, n_overflow);
    if (errors == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
